// ----- design/bfloat16_alu_assert.svh -----
`ifndef BFLOAT16_ALU_ASSERT_SVH
`define BFLOAT16_ALU_ASSERT_SVH

// cond must never hold at a clock edge out of reset
`define BF16A_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// ante at one edge forces cons later, after exactly the delay given by n
`define BF16A_AFTER(lbl, clk, rst_n, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##(n) (cons)) else $error(msg);

// cons at one edge needs ante earlier, by exactly the delay given by n
`define BF16A_SINCE(lbl, clk, rst_n, cons, ante, n, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cons) |-> $past((ante), n)) else $error(msg);

`endif

// ----- design/bf16a_pkg.sv -----
package bf16a_pkg;

    localparam int NumStages = 9;
    localparam int StepsPerStage = 4;
    localparam int Lat = NumStages + 1;
    localparam int ExpW = 11;

    localparam logic [15:0] QuietBit = 16'h0040;
    localparam logic [15:0] CanonNan = 16'h7FC0;
    localparam logic [15:0] MagMask = 16'h7FFF;
    localparam logic [14:0] ExpAll = 15'h7F80;

    typedef enum logic [3:0] {
        CMD_ADD     = 4'd0,
        CMD_SUB     = 4'd1,
        CMD_MUL     = 4'd2,
        CMD_DIV     = 4'd3,
        CMD_SQRT    = 4'd4,
        CMD_ABS     = 4'd5,
        CMD_LESS    = 4'd6,
        CMD_GREATER = 4'd7,
        CMD_EQUAL   = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_MUL  = 2'd1,
        KIND_DIV  = 2'd2,
        KIND_SQRT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [8:0]  r;
        logic [27:0] q;
    } t_div;

    typedef struct packed {
        logic [30:0] r;
        logic [27:0] q;
        logic [9:0]  x;
    } t_sqrt;

    typedef struct packed {
        logic                   valid;
        logic                   special;
        logic [15:0]            spec_res;
        logic                   spec_flag;
        t_kind                  kind;
        logic                   sign;
        logic                   zsign;
        logic signed [ExpW-1:0] exp;
        logic [7:0]             ma;
        logic [7:0]             mb;
        logic [4:0]             add_d;
        logic                   add_sub;
        logic [27:0]            add_sum;
        logic [4:0]             add_lz;
        logic [15:0]            prod;
        t_div                   dv;
        t_sqrt                  sq;
        logic [26:0]            sig;
        logic                   sticky;
        logic                   ovf;
    } t_stage;

    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        logic       found;
        n = 4'd0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 4'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // one restoring quotient bit
    function automatic t_div div_step(input t_div s, input logic [7:0] d);
        t_div       o;
        logic       take;
        logic [8:0] rem;
        take = s.r >= {1'b0, d};
        rem = take ? (s.r - {1'b0, d}) : s.r;
        o.q = {s.q[26:0], take};
        o.r = {rem[7:0], 1'b0};
        return o;
    endfunction

    // one restoring root bit, two radicand bits in
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       o;
        logic [30:0] rem;
        logic [30:0] trial;
        logic        take;
        rem = {s.r[28:0], s.x[9:8]};
        trial = {1'b0, s.q, 2'b01};
        take = rem >= trial;
        o.r = take ? (rem - trial) : rem;
        o.q = {s.q[26:0], take};
        o.x = {s.x[7:0], 2'b00};
        return o;
    endfunction

endpackage

// ----- design/bfloat16_alu.sv -----
// bfloat16 arithmetic unit. Every arithmetic operation is carried out as
// float32 with round-to-nearest-even (subnormals kept) and cut to the upper
// 16 bits. A transaction is taken at each clock edge where start is high;
// busy never rises, so one operation enters every cycle. Its result appears
// on o_result and o_flag, registered after the last pipeline stage, with
// o_strobe high for exactly one cycle, in order; the receiver cannot stall
// and must take every result. The depth is set by the divide and square root
// recurrences, which produce four quotient or root bits per stage over seven
// stages; all operations use the same depth.
module bfloat16_alu import bf16a_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_cmd,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_strobe,
    output logic [15:0] o_result,
    output logic        o_flag
);

    t_stage r_pipe [1:NumStages];
    t_stage n_pipe [1:NumStages];

    logic        r_strobe, r_flag;
    logic [15:0] r_result;
    logic        n_flag;
    logic [15:0] n_result;

    logic        sa, sb, sbe, sx;
    logic [7:0]  ea_f, eb_f, e_a1, e_b1, e_d;
    logic [6:0]  fa, fb;
    logic [7:0]  ra, rb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
    logic [3:0]  lza, lzb;
    logic [7:0]  ma_n, mb_n;
    logic signed [ExpW-1:0] ea_n, eb_n, sq_p, sq_ps;
    logic [15:0] ka, kb;

    assign busy = 1'b0;

    assign sa = i_operand_a[15];
    assign sb = i_operand_b[15];
    assign sbe = sb ^ (i_cmd == CMD_SUB);
    assign sx = sa ^ sb;
    assign ea_f = i_operand_a[14:7];
    assign eb_f = i_operand_b[14:7];
    assign fa = i_operand_a[6:0];
    assign fb = i_operand_b[6:0];
    assign a_nan = i_operand_a[14:0] > ExpAll;
    assign b_nan = i_operand_b[14:0] > ExpAll;
    assign a_inf = i_operand_a[14:0] == ExpAll;
    assign b_inf = i_operand_b[14:0] == ExpAll;
    assign a_zero = i_operand_a[14:0] == 15'd0;
    assign b_zero = i_operand_b[14:0] == 15'd0;

    // raw significands for the adder, subnormals at exponent one
    assign ra = {ea_f != 8'd0, fa};
    assign rb = {eb_f != 8'd0, fb};
    assign e_a1 = (ea_f == 8'd0) ? 8'd1 : ea_f;
    assign e_b1 = (eb_f == 8'd0) ? 8'd1 : eb_f;
    assign a_big = i_operand_a[14:0] >= i_operand_b[14:0];
    assign e_d = a_big ? (e_a1 - e_b1) : (e_b1 - e_a1);

    // normalized significands for multiply, divide and root
    assign lza = lzc8({1'b0, fa});
    assign lzb = lzc8({1'b0, fb});
    assign ma_n = (ea_f != 8'd0) ? {1'b1, fa} : 8'({1'b0, fa} << lza);
    assign mb_n = (eb_f != 8'd0) ? {1'b1, fb} : 8'({1'b0, fb} << lzb);
    assign ea_n = (ea_f != 8'd0) ? $signed({3'b0, ea_f}) : (11'sd1 - $signed({7'b0, lza}));
    assign eb_n = (eb_f != 8'd0) ? $signed({3'b0, eb_f}) : (11'sd1 - $signed({7'b0, lzb}));

    assign sq_p = ea_n - 11'sd134;
    assign sq_ps = sq_p - (sq_p[0] ? 11'sd47 : 11'sd48);

    assign ka = sa ? ~i_operand_a : (i_operand_a | 16'h8000);
    assign kb = sb ? ~i_operand_b : (i_operand_b | 16'h8000);

    always_comb begin
        logic [27:0]            big28, sm28, mask28, al28, norm28;
        logic signed [ExpW-1:0] sh;
        logic [4:0]             sh5;
        logic [26:0]            mask27;

        // stage 1: decode, unpack, special operands, compares
        n_pipe[1] = '0;
        n_pipe[1].valid = start & ~busy;
        n_pipe[1].kind = KIND_ADD;
        case (i_cmd)
            CMD_ADD, CMD_SUB: begin
                n_pipe[1].kind = KIND_ADD;
                n_pipe[1].sign = a_big ? sa : sbe;
                n_pipe[1].zsign = sa & sbe;
                n_pipe[1].exp = $signed({3'b0, a_big ? e_a1 : e_b1});
                n_pipe[1].ma = a_big ? ra : rb;
                n_pipe[1].mb = a_big ? rb : ra;
                n_pipe[1].add_d = (e_d > 8'd31) ? 5'd31 : e_d[4:0];
                n_pipe[1].add_sub = sa ^ sbe;
                n_pipe[1].special = a_nan | b_nan | a_inf | b_inf;
                if (a_nan) n_pipe[1].spec_res = i_operand_a | QuietBit;
                else if (b_nan) n_pipe[1].spec_res = i_operand_b | QuietBit;
                else if (a_inf && b_inf)
                    n_pipe[1].spec_res = (sa != sbe) ? CanonNan : i_operand_a;
                else if (a_inf) n_pipe[1].spec_res = i_operand_a;
                else n_pipe[1].spec_res = {sbe, ExpAll};
            end
            CMD_MUL: begin
                n_pipe[1].kind = KIND_MUL;
                n_pipe[1].sign = sx;
                n_pipe[1].exp = ea_n + eb_n - 11'sd127;
                n_pipe[1].ma = ma_n;
                n_pipe[1].mb = mb_n;
                n_pipe[1].special = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
                if (a_nan) n_pipe[1].spec_res = i_operand_a | QuietBit;
                else if (b_nan) n_pipe[1].spec_res = i_operand_b | QuietBit;
                else if ((a_inf && b_zero) || (a_zero && b_inf)) n_pipe[1].spec_res = CanonNan;
                else if (a_inf || b_inf) n_pipe[1].spec_res = {sx, ExpAll};
                else n_pipe[1].spec_res = {sx, 15'd0};
            end
            CMD_DIV: begin
                n_pipe[1].kind = KIND_DIV;
                n_pipe[1].sign = sx;
                n_pipe[1].exp = ea_n - eb_n + 11'sd127 - ((ma_n < mb_n) ? 11'sd1 : 11'sd0);
                n_pipe[1].ma = ma_n;
                n_pipe[1].mb = mb_n;
                n_pipe[1].dv.r = (ma_n < mb_n) ? {ma_n, 1'b0} : {1'b0, ma_n};
                n_pipe[1].special = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
                if (a_nan) n_pipe[1].spec_res = i_operand_a | QuietBit;
                else if (b_nan) n_pipe[1].spec_res = i_operand_b | QuietBit;
                else if ((a_zero && b_zero) || (a_inf && b_inf)) n_pipe[1].spec_res = CanonNan;
                else if (a_inf || b_zero) n_pipe[1].spec_res = {sx, ExpAll};
                else n_pipe[1].spec_res = {sx, 15'd0};
            end
            CMD_SQRT: begin
                n_pipe[1].kind = KIND_SQRT;
                n_pipe[1].exp = 11'sd154 + (sq_ps >>> 1);
                n_pipe[1].sq.x = sq_p[0] ? {1'b0, ma_n, 1'b0} : {ma_n, 2'b00};
                n_pipe[1].special = a_nan | a_zero | sa | a_inf;
                if (a_nan) n_pipe[1].spec_res = i_operand_a | QuietBit;
                else if (a_zero) n_pipe[1].spec_res = i_operand_a;
                else if (sa) n_pipe[1].spec_res = CanonNan;
                else n_pipe[1].spec_res = i_operand_a;
            end
            CMD_ABS: begin
                n_pipe[1].special = 1'b1;
                n_pipe[1].spec_res = i_operand_a & MagMask;
            end
            CMD_LESS: begin
                n_pipe[1].special = 1'b1;
                n_pipe[1].spec_flag = !a_nan && !b_nan && !(a_zero && b_zero) && (ka < kb);
            end
            CMD_GREATER: begin
                n_pipe[1].special = 1'b1;
                n_pipe[1].spec_flag = !a_nan && !b_nan && !(a_zero && b_zero) && (ka > kb);
            end
            CMD_EQUAL: begin
                n_pipe[1].special = 1'b1;
                n_pipe[1].spec_flag = i_operand_a == i_operand_b;
            end
            default: begin
                n_pipe[1].special = 1'b1;
            end
        endcase

        // stages 2..8: recurrences, plus add and multiply in the early stages
        for (int k = 2; k <= NumStages - 1; k++) begin
            n_pipe[k] = r_pipe[k-1];
            for (int j = 0; j < StepsPerStage; j++) begin
                n_pipe[k].dv = div_step(n_pipe[k].dv, n_pipe[k].mb);
                n_pipe[k].sq = sqrt_step(n_pipe[k].sq);
            end
            big28 = {1'b0, r_pipe[k-1].ma, 19'd0};
            sm28 = {1'b0, r_pipe[k-1].mb, 19'd0};
            mask28 = (28'd1 << r_pipe[k-1].add_d) - 28'd1;
            al28 = (sm28 >> r_pipe[k-1].add_d) | {27'd0, |(sm28 & mask28)};
            norm28 = r_pipe[k-1].add_sum << r_pipe[k-1].add_lz;
            if (k == 2) begin
                n_pipe[k].add_sum = r_pipe[k-1].add_sub ? (big28 - al28) : (big28 + al28);
                n_pipe[k].prod = r_pipe[k-1].ma * r_pipe[k-1].mb;
            end
            if (k == 3) begin
                n_pipe[k].add_lz = lzc28(r_pipe[k-1].add_sum);
                if (r_pipe[k-1].kind == KIND_MUL) begin
                    if (r_pipe[k-1].prod[15]) begin
                        n_pipe[k].sig = {r_pipe[k-1].prod, 11'd0};
                        n_pipe[k].exp = r_pipe[k-1].exp + 11'sd1;
                    end else begin
                        n_pipe[k].sig = {r_pipe[k-1].prod[14:0], 12'd0};
                    end
                    n_pipe[k].sticky = 1'b0;
                end
            end
            if (k == 4 && r_pipe[k-1].kind == KIND_ADD) begin
                if (r_pipe[k-1].add_sum == 28'd0 && !r_pipe[k-1].special) begin
                    n_pipe[k].special = 1'b1;
                    n_pipe[k].spec_res = {r_pipe[k-1].zsign, 15'd0};
                end
                n_pipe[k].sig = norm28[27:1];
                n_pipe[k].sticky = norm28[0];
                n_pipe[k].exp = r_pipe[k-1].exp + 11'sd1 - $signed({6'd0, r_pipe[k-1].add_lz});
            end
            if (k == NumStages - 1) begin
                if (r_pipe[k-1].kind == KIND_DIV) begin
                    n_pipe[k].sig = n_pipe[k].dv.q[27:1];
                    n_pipe[k].sticky = n_pipe[k].dv.q[0] | (n_pipe[k].dv.r != 9'd0);
                end
                if (r_pipe[k-1].kind == KIND_SQRT) begin
                    n_pipe[k].sig = n_pipe[k].sq.q[27:1];
                    n_pipe[k].sticky = n_pipe[k].sq.q[0] | (n_pipe[k].sq.r != 31'd0);
                end
            end
        end

        // last stage: shift subnormal results down, flag overflow
        n_pipe[NumStages] = r_pipe[NumStages-1];
        sh = 11'sd1 - r_pipe[NumStages-1].exp;
        sh5 = (sh > 11'sd31) ? 5'd31 : sh[4:0];
        mask27 = (27'd1 << sh5) - 27'd1;
        n_pipe[NumStages].ovf = r_pipe[NumStages-1].exp >= 11'sd255;
        if (r_pipe[NumStages-1].exp <= 11'sd0) begin
            n_pipe[NumStages].sig = r_pipe[NumStages-1].sig >> sh5;
            n_pipe[NumStages].sticky = r_pipe[NumStages-1].sticky
                | (|(r_pipe[NumStages-1].sig & mask27));
            n_pipe[NumStages].exp = '0;
        end
    end

    // round to nearest even, pack, keep the upper half
    always_comb begin
        logic        up;
        logic [30:0] mag;
        logic [31:0] word;
        up = r_pipe[NumStages].sig[2] & (r_pipe[NumStages].sig[3] | r_pipe[NumStages].sig[1]
            | r_pipe[NumStages].sig[0] | r_pipe[NumStages].sticky);
        mag = {r_pipe[NumStages].exp[7:0], r_pipe[NumStages].sig[25:3]} + {30'd0, up};
        word = r_pipe[NumStages].ovf ? {r_pipe[NumStages].sign, 8'hFF, 23'd0}
                                     : {r_pipe[NumStages].sign, mag};
        if (r_pipe[NumStages].special) begin
            n_result = r_pipe[NumStages].spec_res;
            n_flag = r_pipe[NumStages].valid & r_pipe[NumStages].spec_flag;
        end else begin
            n_result = word[31:16];
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            for (int k = 1; k <= NumStages; k++) r_pipe[k].valid <= 1'b0;
            r_strobe <= 1'b0;
            r_flag <= 1'b0;
        end else begin
            r_pipe <= n_pipe;
            r_strobe <= r_pipe[NumStages].valid;
            r_flag <= n_flag;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign o_flag = r_flag;

endmodule

// ----- design/bf16a_checker.sv -----
`include "bfloat16_alu_assert.svh"

module bf16a_checker import bf16a_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [15:0] o_result,
    input logic        o_flag
);

    `BF16A_NEVER(a_no_busy, i_clk, i_rst_n, busy, "busy raised")
    `BF16A_AFTER(a_result_due, i_clk, i_rst_n, start && !busy, Lat, o_strobe, "result missing")
    `BF16A_SINCE(a_result_owed, i_clk, i_rst_n, o_strobe, start && !busy, Lat, "spurious result")
    `BF16A_NEVER(a_flag_clean, i_clk, i_rst_n, o_flag && (!o_strobe || o_result != 16'd0), "flag with data")

endmodule

bind bfloat16_alu bf16a_checker u_bf16a_checker (.*);
